FILE: sv/sai_pkg.sv
// sai_pkg: shared types and codes for the shift/insert array.
// Holds command and status codes and the per-cell control struct.
// No dependencies; imported by sai_cell and shift_insert_array.
package sai_pkg;

  // Command codes carried by one transaction
  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_PREPEND  = 3'd1,
    CMD_ERASE    = 3'd2,
    CMD_READ     = 3'd3,
    CMD_CONTAINS = 3'd4,
    CMD_CLEAR    = 3'd5
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Per-cell update controls driven by the array controller
  typedef struct packed {
    logic load;       // take the command word
    logic from_prev;  // take the lower neighbor's entry (shift up)
    logic from_next;  // take the upper neighbor's entry (shift down)
    logic held;       // entry is below the fill count
  } cell_ctrl_t;

endpackage

FILE: sv/sai_cell.sv
// sai_cell: one storage cell of the shift/insert array.
// Holds one entry, shifts to/from its neighbors and registers a compare hit.
// Depends on sai_pkg for cell_ctrl_t.
module sai_cell import sai_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [WIDTH-1:0] word_i,
  input  logic [WIDTH-1:0] prev_i,
  input  logic [WIDTH-1:0] next_i,
  output logic [WIDTH-1:0] data_o,
  output logic             hit_o
);

  logic [WIDTH-1:0] data_q, data_d;
  logic             hit_q, hit_d;

  // Select the new entry: load, shift up, shift down or hold
  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = word_i;
    end else if (ctrl_i.from_prev) begin
      data_d = prev_i;
    end else if (ctrl_i.from_next) begin
      data_d = next_i;
    end
  end

  // Compare the held entry against the command word
  assign hit_d = ctrl_i.held && (data_q == word_i);

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    hit_q  <= hit_d;
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

FILE: sv/shift_insert_array.sv
// shift_insert_array: fixed-capacity ordered array of DEPTH words.
// Command channel: start_i with command_i, value_i, position_i; a transaction
//   is taken at a rising edge with start_i high and busy_o low. busy_o is
//   never raised, so one transaction can be taken every cycle.
// Result channel: done_o marks read_data_o, found_o, count_o and status_o for
//   exactly one cycle, in the cycle after the command transaction was taken.
//   The receiver cannot stall; results are never held.
// Throughput 1 transaction per cycle. Every cell updates in
//   the same cycle (load, shift up or shift down) and registers its own
//   compare hit; the result stage ORs the DEPTH hit bits for contains.
// Append/prepend into a full array answer status full; erase/read at or past
//   the count answer status range with read_data_o zero. Clear only zeroes
//   the count.
// Reset empties the array (count 0) and drops any pending result; entries
//   are not cleared and never show before they are written.
// Depends on sai_pkg and sai_cell.
module shift_insert_array import sai_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] value_i,
  input  logic [3:0]  position_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic        found_o,
  output logic [4:0]  count_o,
  output logic [1:0]  status_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > 4) ? CW : 4;
  localparam int unsigned RD = (DEPTH < 16) ? DEPTH : 16;

  cmd_e             cmd;
  logic [WIDTH-1:0] word;
  logic [PW-1:0]    pos_ext, cnt_ext;
  logic             accept, full, in_range;
  logic             push_ok, erase_ok;

  logic [CW-1:0]    fill_q, fill_d;
  logic [WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] cell_hit;

  logic [WIDTH-1:0] rd_word;
  status_e          status_d;

  logic             done_q;
  logic             cont_q;
  logic [WIDTH-1:0] rdata_q, rdata_d;
  logic [CW-1:0]    cnt_q;
  status_e          status_q;

  // Command decode
  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign cmd      = cmd_e'(command_i);
  assign word     = WIDTH'(value_i);
  assign pos_ext  = PW'(position_i);
  assign cnt_ext  = PW'(fill_q);
  assign full     = (fill_q == CW'(DEPTH));
  assign in_range = (pos_ext < cnt_ext);
  assign push_ok  = accept && !full && (cmd == CMD_APPEND || cmd == CMD_PREPEND);
  assign erase_ok = accept && in_range && (cmd == CMD_ERASE);

  // Per-cell controls and the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] prev_w, next_w;
    cell_ctrl_t       ctrl_w;

    always_comb begin
      ctrl_w.load      = push_ok && (((cmd == CMD_APPEND) && (fill_q == CW'(i)))
                                    || ((cmd == CMD_PREPEND) && (i == 0)));
      ctrl_w.from_prev = push_ok && (cmd == CMD_PREPEND) && (i != 0);
      ctrl_w.from_next = erase_ok && (i != DEPTH - 1) && (PW'(i) >= pos_ext);
      ctrl_w.held      = (CW'(i) < fill_q);
    end

    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_hi
      assign next_w = cell_data[i+1];
    end

    sai_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_w),
      .word_i (word),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[i]),
      .hit_o  (cell_hit[i])
    );
  end

  // Pick the addressed entry among the cells a position can reach
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < RD; k++) begin
      if (position_i == 4'(k)) begin
        rd_word = cell_data[k];
      end
    end
  end

  // Status, read data and next count
  always_comb begin
    status_d = ST_OK;
    rdata_d  = '0;
    fill_d   = fill_q;
    case (cmd)
      CMD_APPEND, CMD_PREPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          fill_d = fill_q + CW'(1);
        end
      end
      CMD_ERASE: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          fill_d = fill_q - CW'(1);
        end
      end
      CMD_READ: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          rdata_d = rd_word;
        end
      end
      CMD_CLEAR: begin
        fill_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers: fill count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cont_q   <= (cmd == CMD_CONTAINS);
      rdata_q  <= rdata_d;
      cnt_q    <= fill_d;
      status_q <= status_d;
    end
  end

  // Drive the result ports
  assign done_o      = done_q;
  assign read_data_o = 32'(rdata_q);
  assign found_o     = cont_q && (|cell_hit);
  assign count_o     = 5'(cnt_q);
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill count beyond capacity");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("command without a result");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == CMD_APPEND && !full) |=> (fill_q == $past(fill_q) + CW'(1)))
    else $error("append did not grow the array");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (cnt_q == CW'(DEPTH)))
    else $error("full status with room left");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_RANGE) |-> (read_data_o == '0 && !found_o))
    else $error("range error carries data");
`endif

endmodule
